/* rtl/vtpg_pkg.sv */
`timescale 1ns / 1ps
// Package for the video test pattern generator: mode and color codes,
// geometry constants and the sweep ROM contents. No dependencies.
package vtpg_pkg;

    typedef enum logic [2:0] {
        ModeColorBar = 3'd0,
        ModeGrayBar  = 3'd1,
        ModeCard     = 3'd2,
        ModeRed      = 3'd3,
        ModeGreen    = 3'd4,
        ModeBlue     = 3'd5,
        ModeWhite    = 3'd6,
        ModeBlack    = 3'd7
    } mode_t;

    typedef enum logic [4:0] {
        ColWhite    = 5'd0,
        ColDkYellow = 5'd1,
        ColDkCyan   = 5'd2,
        ColDkGreen  = 5'd3,
        ColDkMag    = 5'd4,
        ColDkRed    = 5'd5,
        ColDkBlue   = 5'd6,
        ColBlack    = 5'd7,
        ColRed      = 5'd8,
        ColGreen    = 5'd9,
        ColBlue     = 5'd10,
        ColGray0    = 5'd11,
        ColGray1    = 5'd12,
        ColGray2    = 5'd13,
        ColGray3    = 5'd14,
        ColGray4    = 5'd15,
        ColGray5    = 5'd16,
        ColGray6    = 5'd17,
        ColGray7    = 5'd18
    } color_t;

    typedef enum logic [1:0] {
        BandColor = 2'd0,
        BandGray  = 2'd1,
        BandLabel = 2'd2,
        BandSweep = 2'd3
    } band_t;

    localparam int FrameW    = 720;
    localparam int FrameH    = 576;
    localparam int BarW      = FrameW / 8;
    localparam int GridStep  = 44;
    localparam int GridX0    = 6;
    localparam int GridY0    = 34;
    localparam int GridThick = 3;
    localparam int CardX0    = 140;
    localparam int CardW     = 440;
    localparam int CardY0    = 80;
    localparam int GrayY0    = 160;
    localparam int LabelY0   = 240;
    localparam int SweepY0   = 320;
    localparam int SweepH    = 160;
    localparam int BlockW    = 55;

    // Division by 44 as multiplication by a reciprocal, exact for all 10-bit values.
    localparam int RecipShift = 21;
    localparam logic [15:0] Recip44 = 16'd47663;

    function automatic logic [511:0] sweep_rom_f();
        logic [511:0] rom;
        int start;
        int w;
        logic ph;
        rom   = '0;
        start = 0;
        ph    = 1'b0;
        w     = CardW / GridStep + 1;
        for (int off = 0; off < CardW; off++) begin
            if (off >= start + w) begin
                start = start + w;
                ph    = ~ph;
                w     = (CardW - start) / GridStep + 1;
            end
            rom[off] = ph;
        end
        return rom;
    endfunction

    localparam logic [511:0] SweepRom = sweep_rom_f();

endpackage

/* rtl/vtpg_grid.sv */
`timescale 1ns / 1ps
// Grid line detector: tests whether a coordinate offset lies on a 3-pixel line
// repeating every 44 pixels. Uses vtpg_pkg; one register stage inside.
module vtpg_grid
    import vtpg_pkg::*;
(
    input  logic       aclk,
    input  logic       adv_b,
    input  logic [9:0] n_a,
    input  logic       ge_a,
    output logic       hit
);

    logic [25:0] prod;
    logic [4:0]  q_next;
    logic [4:0]  q_reg;
    logic [9:0]  n_reg;
    logic        ge_reg;
    logic [9:0]  mult44;
    logic [9:0]  rem;

    assign prod   = 26'(n_a) * 26'(Recip44);
    assign q_next = prod[RecipShift +: 5];

    always_ff @(posedge aclk) begin
        if (adv_b) begin
            q_reg  <= q_next;
            n_reg  <= n_a;
            ge_reg <= ge_a;
        end
    end

    assign mult44 = (10'(q_reg) << 5) + (10'(q_reg) << 3) + (10'(q_reg) << 2);
    assign rem    = n_reg - mult44;
    assign hit    = ge_reg && (rem < 10'(GridThick));

endmodule

/* rtl/video_test_pattern_generator_top.sv */
`timescale 1ns / 1ps
// Video test pattern generator top level: mode register and a three-stage pixel
// pipeline, stages a, b and c, each registered. Throughput is one pixel per cycle
// while m_ready stays high, set by the fully pipelined stages. A stage holds only
// while it is valid and the stage after it is stalled. Synchronous active-low reset
// clears all valid bits and sets the mode to color bars. Uses vtpg_pkg and vtpg_grid.
module video_test_pattern_generator_top
    import vtpg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [9:0] s_pixel_x,
    input  logic [9:0] s_pixel_y,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_color_code
);

    mode_t  mode_reg;

    logic   adv_a;
    logic   adv_b;
    logic   adv_c;

    logic   a_valid_reg;
    logic   a_frame_reg;
    logic   a_card_reg;
    band_t  a_band_reg;
    logic [2:0] a_bar_reg;
    logic [8:0] a_off_reg;
    logic [9:0] a_xm_reg;
    logic [9:0] a_ym_reg;
    logic   a_xge_reg;
    logic   a_yge_reg;

    logic   a_frame_next;
    logic   a_card_next;
    band_t  a_band_next;
    logic [2:0] a_bar_next;

    logic   b_valid_reg;
    logic   b_frame_reg;
    logic   b_card_reg;
    band_t  b_band_reg;
    logic [2:0] b_bar_reg;
    logic [2:0] b_blk_reg;
    logic   b_sweep_reg;
    logic [2:0] b_blk_next;

    logic   hit_x;
    logic   hit_y;

    logic   c_valid_reg;
    color_t c_color_reg;
    color_t c_color_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ModeColorBar;
        end else if (cfg_valid) begin
            mode_reg <= mode_t'(cfg_mode);
        end
    end

    assign adv_c   = !c_valid_reg || m_ready;
    assign adv_b   = !b_valid_reg || adv_c;
    assign adv_a   = !a_valid_reg || adv_b;
    assign s_ready = adv_a;

    always_comb begin
        a_frame_next = (s_pixel_x < 10'(FrameW)) && (s_pixel_y < 10'(FrameH));
        a_card_next  = (s_pixel_x >= 10'(CardX0)) && (s_pixel_x < 10'(CardX0 + CardW))
                    && (s_pixel_y >= 10'(CardY0)) && (s_pixel_y < 10'(SweepY0 + SweepH));
        if (s_pixel_y < 10'(GrayY0)) begin
            a_band_next = BandColor;
        end else if (s_pixel_y < 10'(LabelY0)) begin
            a_band_next = BandGray;
        end else if (s_pixel_y < 10'(SweepY0)) begin
            a_band_next = BandLabel;
        end else begin
            a_band_next = BandSweep;
        end
        a_bar_next = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (s_pixel_x >= 10'(k * BarW)) begin
                a_bar_next = 3'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv_a) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            a_frame_reg <= a_frame_next;
            a_card_reg  <= a_card_next;
            a_band_reg  <= a_band_next;
            a_bar_reg   <= a_bar_next;
            a_off_reg   <= 9'(s_pixel_x - 10'(CardX0));
            a_xm_reg    <= s_pixel_x - 10'(GridX0);
            a_ym_reg    <= s_pixel_y - 10'(GridY0);
            a_xge_reg   <= s_pixel_x >= 10'(GridX0);
            a_yge_reg   <= s_pixel_y >= 10'(GridY0);
        end
    end

    always_comb begin
        b_blk_next = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (a_off_reg >= 9'(k * BlockW)) begin
                b_blk_next = 3'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_b) begin
            b_frame_reg <= a_frame_reg;
            b_card_reg  <= a_card_reg;
            b_band_reg  <= a_band_reg;
            b_bar_reg   <= a_bar_reg;
            b_blk_reg   <= b_blk_next;
            b_sweep_reg <= SweepRom[a_off_reg];
        end
    end

    vtpg_grid u_grid_x (
        .aclk  (aclk),
        .adv_b (adv_b),
        .n_a   (a_xm_reg),
        .ge_a  (a_xge_reg),
        .hit   (hit_x)
    );

    vtpg_grid u_grid_y (
        .aclk  (aclk),
        .adv_b (adv_b),
        .n_a   (a_ym_reg),
        .ge_a  (a_yge_reg),
        .hit   (hit_y)
    );

    always_comb begin
        c_color_next = ColBlack;
        if (b_frame_reg) begin
            case (mode_reg)
                ModeColorBar: c_color_next = color_t'(5'(b_bar_reg));
                ModeGrayBar:  c_color_next = color_t'(ColGray0 + 5'(b_bar_reg));
                ModeCard: begin
                    if (b_card_reg) begin
                        case (b_band_reg)
                            BandColor: c_color_next = color_t'(5'(b_blk_reg));
                            BandGray:  c_color_next = color_t'(ColGray0 + 5'(b_blk_reg));
                            BandLabel: c_color_next = ColBlack;
                            BandSweep: c_color_next = b_sweep_reg ? ColWhite : ColBlack;
                            default:   c_color_next = ColBlack;
                        endcase
                    end else if (hit_x || hit_y) begin
                        c_color_next = ColWhite;
                    end else begin
                        c_color_next = ColGray2;
                    end
                end
                ModeRed:   c_color_next = ColRed;
                ModeGreen: c_color_next = ColGreen;
                ModeBlue:  c_color_next = ColBlue;
                ModeWhite: c_color_next = ColWhite;
                default:   c_color_next = ColBlack;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv_c) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_c) begin
            c_color_reg <= c_color_next;
        end
    end

    assign m_valid      = c_valid_reg;
    assign m_color_code = c_color_reg;

endmodule

/* rtl/vtpg_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the video test pattern generator, bound to the top level.
// Uses vtpg_pkg for the color code range.
module vtpg_checker
    import vtpg_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_color_code
);

    // A request passes stages a, b and c and reaches the output when m_ready stays high meanwhile.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready ##1 m_ready ##1 m_ready) |=> m_valid)
        else $error("request did not reach the output after three cycles");

    // The input side only stalls when the pipeline is full and the output is blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the pipeline could advance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_color_code <= ColGray7))
        else $error("color code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_color_code)))
        else $error("stalled result changed");

endmodule

bind video_test_pattern_generator_top vtpg_checker u_vtpg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_color_code (m_color_code)
);

/* dv/video_test_pattern_generator_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for video_test_pattern_generator_top: directed and random
// pixel requests over all modes, with an independent color predictor and random stalls.
// Depends on vtpg_pkg (mode_t, color_t) and the top-level RTL.
module video_test_pattern_generator_top_tb;
    import vtpg_pkg::*;

    localparam int ClkHalf     = 6;
    localparam int ResetCycles = 10;
    localparam int SettleWait  = 8;
    localparam int IdleLimit   = 1000;

    localparam int PxFrameW  = 720;
    localparam int PxFrameH  = 576;
    localparam int PxBarW    = 90;
    localparam int PxStep    = 44;
    localparam int PxGridX0  = 6;
    localparam int PxGridY0  = 34;
    localparam int PxThick   = 3;
    localparam int PxCardX0  = 140;
    localparam int PxCardW   = 440;
    localparam int PxBlockW  = 55;
    localparam int PxCardY0  = 80;
    localparam int PxGrayY0  = 160;
    localparam int PxLabelY0 = 240;
    localparam int PxSweepY0 = 320;
    localparam int PxSweepY1 = 480;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
    } pixel_req_t;

    typedef struct {
        logic [9:0] x;
        logic [9:0] y;
        color_t     color;
    } color_exp_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_mode = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [9:0] s_pixel_x = '0;
    logic [9:0] s_pixel_y = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [4:0] m_color_code;

    pixel_req_t pending_pixels[$];
    color_exp_t expected_colors[$];
    pixel_req_t cur_pixel;
    mode_t      active_mode = ModeColorBar;
    bit         no_idle = 1'b0;
    bit         s_busy = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         idle_cycles = 0;
    int         mismatch_count = 0;

    video_test_pattern_generator_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_mode    (cfg_mode),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_x   (s_pixel_x),
        .s_pixel_y   (s_pixel_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_color_code(m_color_code)
    );

    initial begin
        forever #ClkHalf aclk = ~aclk;
    end

    function automatic bit sweep_is_white(int off);
        int start;
        int w;
        bit ph;
        start = 0;
        ph    = 1'b0;
        while (start < PxCardW) begin
            w = (PxCardW - start) / PxStep + 1;
            if (off < start + w) begin
                return ph;
            end
            start = start + w;
            ph    = ~ph;
        end
        return 1'b0;
    endfunction

    function automatic color_t card_color(int x, int y);
        int off;
        int blk;
        if (x >= PxCardX0 && x < PxCardX0 + PxCardW && y >= PxCardY0 && y < PxSweepY1) begin
            off = x - PxCardX0;
            blk = off / PxBlockW;
            if (y < PxGrayY0) begin
                return color_t'(blk);
            end
            if (y < PxLabelY0) begin
                return color_t'(ColGray0 + blk);
            end
            if (y < PxSweepY0) begin
                return ColBlack;
            end
            return sweep_is_white(off) ? ColWhite : ColBlack;
        end
        if ((x >= PxGridX0 && (x - PxGridX0) % PxStep < PxThick) ||
            (y >= PxGridY0 && (y - PxGridY0) % PxStep < PxThick)) begin
            return ColWhite;
        end
        return ColGray2;
    endfunction

    function automatic color_t predict_color(mode_t md, logic [9:0] px, logic [9:0] py);
        int x;
        int y;
        x = int'(px);
        y = int'(py);
        if (x >= PxFrameW || y >= PxFrameH) begin
            return ColBlack;
        end
        case (md)
            ModeColorBar: return color_t'(x / PxBarW);
            ModeGrayBar:  return color_t'(ColGray0 + x / PxBarW);
            ModeCard:     return card_color(x, y);
            ModeRed:      return ColRed;
            ModeGreen:    return ColGreen;
            ModeBlue:     return ColBlue;
            ModeWhite:    return ColWhite;
            default:      return ColBlack;
        endcase
    endfunction

    function automatic logic [9:0] pick_coord(int frame_max, int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return 10'($urandom_range(0, 1023));
        end
        if (r < 50) begin
            return 10'($urandom_range(lo, hi));
        end
        return 10'($urandom_range(0, frame_max));
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_pixel(int x, int y);
        pending_pixels.push_back('{x: 10'(x), y: 10'(y)});
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_busy || expected_colors.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SettleWait) @(posedge aclk);
    endtask

    task automatic write_mode(mode_t md);
        cfg_mode  <= md;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid   <= 1'b0;
        active_mode = md;
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_colors.push_back('{x: cur_pixel.x, y: cur_pixel.y,
                    color: predict_color(active_mode, cur_pixel.x, cur_pixel.y)});
                s_busy   = 1'b0;
                gap_left = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (!s_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_pixels.size() != 0) begin
                    cur_pixel = pending_pixels.pop_front();
                    s_busy    = 1'b1;
                    s_pixel_x <= cur_pixel.x;
                    s_pixel_y <= cur_pixel.y;
                end
            end
            s_valid <= s_busy;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        color_exp_t exp_item;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("unexpected result color_code=%0d", m_color_code));
                end else begin
                    exp_item = expected_colors.pop_front();
                    if (m_color_code !== exp_item.color) begin
                        report_mismatch($sformatf("x=%0d y=%0d color_code=%0d expected %0d",
                            exp_item.x, exp_item.y, m_color_code, exp_item.color));
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IdleLimit) begin
            @(posedge aclk);
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        mode_t md;
        int    n;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        write_mode(ModeCard);
        add_pixel(0, 0);
        add_pixel(1023, 1023);
        add_pixel(720, 100);
        add_pixel(100, 576);
        add_pixel(719, 575);
        add_pixel(5, 33);
        add_pixel(6, 34);
        add_pixel(8, 36);
        add_pixel(9, 37);
        add_pixel(139, 100);
        add_pixel(140, 80);
        add_pixel(194, 159);
        add_pixel(195, 160);
        add_pixel(300, 250);
        add_pixel(140, 320);
        add_pixel(150, 400);
        add_pixel(578, 330);
        add_pixel(579, 479);
        add_pixel(580, 300);
        wait_drained();

        write_mode(ModeColorBar);
        add_pixel(89, 10);
        add_pixel(90, 10);
        add_pixel(719, 0);
        add_pixel(720, 0);
        add_pixel(0, 1023);
        wait_drained();

        for (int p = 0; p < 12; p++) begin
            if (p < 8) begin
                md = mode_t'(p);
            end else if (p == 8) begin
                md = ModeCard;
            end else if (p == 11) begin
                md = ModeBlack;
            end else begin
                md = mode_t'($urandom_range(0, 7));
            end
            write_mode(md);
            no_idle = (p % 4 == 3);
            n = (md == ModeCard) ? 150 : 80;
            for (int i = 0; i < n; i++) begin
                if (md == ModeCard) begin
                    add_pixel(pick_coord(PxFrameW - 1, 130, 590),
                              pick_coord(PxFrameH - 1, 70, 490));
                end else begin
                    add_pixel(pick_coord(PxFrameW - 1, 0, PxFrameW - 1),
                              pick_coord(PxFrameH - 1, 0, PxFrameH - 1));
                end
                if (p == 5 && i == n / 2) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
